### design/dfw_pkg.sv
package dfw_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;

  localparam int NODE_W = 7;   // node id, 0..MAX_NODES
  localparam int ROW_AW = 6;   // row / visited index
  localparam int EDGE_AW = 8;  // edge store and stack index
  localparam int CNT_W = 9;    // counts up to MAX_EDGES

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_WALK = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_CHK,
    ST_ROW,
    ST_PUSH,
    ST_FIN,
    ST_ERR
  } walk_state_t;

  typedef struct packed {
    logic              append;
    logic              clear;
    logic [NODE_W-1:0] vertex;
    logic              row_end;
  } load_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]   len;
    logic [EDGE_AW-1:0] first;
  } row_info_t;

endpackage

### design/dfw_graph.sv
module dfw_graph (
  input  logic                             clk,
  input  logic                             rst,
  input  dfw_pkg::load_cmd_t               cmd,
  input  logic [dfw_pkg::ROW_AW-1:0]       row_addr,
  output dfw_pkg::row_info_t               row_info,
  input  logic [dfw_pkg::EDGE_AW-1:0]      edge_addr,
  output logic [dfw_pkg::NODE_W-1:0]       edge_data
);

  logic [dfw_pkg::NODE_W-1:0] edge_mem [dfw_pkg::MAX_EDGES];
  dfw_pkg::row_info_t         row_mem [dfw_pkg::MAX_NODES];
  logic [dfw_pkg::MAX_NODES-1:0] row_valid;

  logic [dfw_pkg::NODE_W-1:0]  load_row;
  logic [dfw_pkg::CNT_W-1:0]   edge_total;
  logic [dfw_pkg::CNT_W-1:0]   cur_len;
  logic [dfw_pkg::EDGE_AW-1:0] cur_first;

  dfw_pkg::row_info_t row_q;
  logic               row_vq;

  logic                        row_open;
  logic                        can_append;
  logic [dfw_pkg::EDGE_AW-1:0] first_now;

  assign row_open = load_row < dfw_pkg::NODE_W'(dfw_pkg::MAX_NODES);
  assign can_append = cmd.append && row_open &&
                      (edge_total < dfw_pkg::CNT_W'(dfw_pkg::MAX_EDGES));
  assign first_now = (cur_len == '0) ? edge_total[dfw_pkg::EDGE_AW-1:0] : cur_first;

  // edge store and row table: one write port (loading), one registered read each
  always_ff @(posedge clk) begin
    if (can_append) begin
      edge_mem[edge_total[dfw_pkg::EDGE_AW-1:0]] <= cmd.vertex;
      row_mem[load_row[dfw_pkg::ROW_AW-1:0]] <= '{len: cur_len + 1'b1, first: first_now};
    end
    edge_data <= edge_mem[edge_addr];
    row_q <= row_mem[row_addr];
    row_vq <= row_valid[row_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      load_row <= '0;
      edge_total <= '0;
      cur_len <= '0;
      row_valid <= '0;
    end else begin
      if (can_append) begin
        edge_total <= edge_total + 1'b1;
        row_valid[load_row[dfw_pkg::ROW_AW-1:0]] <= 1'b1;
      end
      // a new row always starts empty
      if (cmd.append && cmd.row_end && row_open) begin
        load_row <= load_row + 1'b1;
        cur_len <= '0;
      end else if (can_append) begin
        cur_len <= cur_len + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_append) begin
      cur_first <= first_now;
    end
  end

  assign row_info = row_vq ? row_q : '0;

endmodule

### design/dfw_walker.sv
module dfw_walker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         walk_go,
  input  logic [dfw_pkg::NODE_W-1:0]   start_vertex,
  input  logic [dfw_pkg::NODE_W-1:0]   nn,
  output logic                         busy,
  output logic [dfw_pkg::ROW_AW-1:0]   row_addr,
  input  dfw_pkg::row_info_t           row_info,
  output logic [dfw_pkg::EDGE_AW-1:0]  edge_addr,
  input  logic [dfw_pkg::NODE_W-1:0]   edge_data,
  output logic                         result_stb,
  output logic [dfw_pkg::NODE_W-1:0]   visited_node,
  output logic                         last,
  output logic [1:0]                   status
);

  logic [dfw_pkg::NODE_W-1:0] stack_mem [dfw_pkg::MAX_EDGES];
  logic [dfw_pkg::NODE_W-1:0] stack_q;

  dfw_pkg::walk_state_t state, state_next;

  logic [dfw_pkg::CNT_W-1:0]     sp, sp_next;
  logic [dfw_pkg::NODE_W-1:0]    seen, seen_next;
  logic [dfw_pkg::MAX_NODES-1:0] visited, visited_next;
  logic                          held_valid, held_valid_next;
  logic [dfw_pkg::NODE_W-1:0]    held_node, held_node_next;
  logic [dfw_pkg::CNT_W-1:0]     k, k_next;
  logic [dfw_pkg::EDGE_AW-1:0]   base, base_next;
  logic                          pend, pend_next;
  logic [1:0]                    err_status, err_status_next;

  logic                          stk_we;
  logic [dfw_pkg::EDGE_AW-1:0]   stk_waddr;
  logic [dfw_pkg::NODE_W-1:0]    stk_wdata;
  logic [dfw_pkg::CNT_W-1:0]     sp_m1;

  logic                          emit;
  logic [dfw_pkg::NODE_W-1:0]    emit_node;
  logic                          emit_last;
  logic [1:0]                    emit_status;

  logic                          e_bad;
  logic [dfw_pkg::ROW_AW-1:0]    e_idx;
  logic [dfw_pkg::CNT_W-1:0]     edge_sum;
  logic [dfw_pkg::CNT_W:0]       push_top;

  assign sp_m1 = sp - 1'b1;
  assign e_bad = (stack_q == '0) || (stack_q > nn);
  assign e_idx = dfw_pkg::ROW_AW'(stack_q - 1'b1);
  assign row_addr = e_idx;
  assign edge_sum = {1'b0, base} + k - 1'b1;
  assign edge_addr = edge_sum[dfw_pkg::EDGE_AW-1:0];
  assign push_top = {1'b0, sp} + {1'b0, row_info.len};
  assign busy = (state != dfw_pkg::ST_IDLE);

  // stack memory, read at top-of-stack every cycle
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stack_q <= stack_mem[sp_m1[dfw_pkg::EDGE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfw_pkg::ST_IDLE;
      sp <= '0;
      visited <= '0;
      held_valid <= 1'b0;
      pend <= 1'b0;
      result_stb <= 1'b0;
    end else begin
      state <= state_next;
      sp <= sp_next;
      visited <= visited_next;
      held_valid <= held_valid_next;
      pend <= pend_next;
      result_stb <= emit;
    end
  end

  always_ff @(posedge clk) begin
    seen <= seen_next;
    held_node <= held_node_next;
    k <= k_next;
    base <= base_next;
    err_status <= err_status_next;
    visited_node <= emit_node;
    last <= emit_last;
    status <= emit_status;
  end

  // the newest visit is held back one result so that its last flag is known
  always_comb begin
    state_next = state;
    sp_next = sp;
    seen_next = seen;
    visited_next = visited;
    held_valid_next = held_valid;
    held_node_next = held_node;
    k_next = k;
    base_next = base;
    pend_next = pend;
    err_status_next = err_status;
    stk_we = 1'b0;
    stk_waddr = sp[dfw_pkg::EDGE_AW-1:0];
    stk_wdata = edge_data;
    emit = 1'b0;
    emit_node = held_node;
    emit_last = 1'b0;
    emit_status = dfw_pkg::STATUS_OK;
    unique case (state)
      dfw_pkg::ST_IDLE: begin
        if (walk_go) begin
          visited_next = '0;
          seen_next = '0;
          held_valid_next = 1'b0;
          sp_next = '0;
          if (start_vertex == '0 || start_vertex > nn) begin
            err_status_next = dfw_pkg::STATUS_RANGE;
            state_next = dfw_pkg::ST_ERR;
          end else begin
            stk_we = 1'b1;
            stk_waddr = '0;
            stk_wdata = start_vertex;
            sp_next = dfw_pkg::CNT_W'(1);
            state_next = dfw_pkg::ST_POP_RD;
          end
        end
      end
      dfw_pkg::ST_POP_RD: begin
        if (sp == '0) begin
          state_next = dfw_pkg::ST_FIN;
        end else begin
          sp_next = sp_m1;
          state_next = dfw_pkg::ST_POP_CHK;
        end
      end
      dfw_pkg::ST_POP_CHK: begin
        if (e_bad) begin
          err_status_next = dfw_pkg::STATUS_RANGE;
          state_next = dfw_pkg::ST_ERR;
        end else if (visited[e_idx]) begin
          state_next = dfw_pkg::ST_POP_RD;
        end else begin
          visited_next[e_idx] = 1'b1;
          emit = held_valid;
          held_valid_next = 1'b1;
          held_node_next = stack_q;
          seen_next = seen + 1'b1;
          if (seen_next >= nn) begin
            state_next = dfw_pkg::ST_FIN;
          end else begin
            state_next = dfw_pkg::ST_ROW;
          end
        end
      end
      dfw_pkg::ST_ROW: begin
        if (push_top > (dfw_pkg::CNT_W + 1)'(dfw_pkg::MAX_EDGES)) begin
          err_status_next = dfw_pkg::STATUS_OVERFLOW;
          state_next = dfw_pkg::ST_ERR;
        end else begin
          k_next = row_info.len;
          base_next = row_info.first;
          pend_next = 1'b0;
          state_next = dfw_pkg::ST_PUSH;
        end
      end
      dfw_pkg::ST_PUSH: begin
        // neighbors go on last-first; edge read and stack write overlap
        if (k != '0) begin
          k_next = k - 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          stk_we = 1'b1;
          sp_next = sp + 1'b1;
        end
        if (k == '0 && !pend) begin
          state_next = dfw_pkg::ST_POP_RD;
        end
      end
      dfw_pkg::ST_FIN: begin
        emit = 1'b1;
        emit_last = 1'b1;
        held_valid_next = 1'b0;
        state_next = dfw_pkg::ST_IDLE;
      end
      dfw_pkg::ST_ERR: begin
        emit = 1'b1;
        if (held_valid) begin
          held_valid_next = 1'b0;
        end else begin
          emit_node = '0;
          emit_last = 1'b1;
          emit_status = err_status;
          state_next = dfw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dfw_pkg::ST_IDLE;
      end
    endcase
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= dfw_pkg::CNT_W'(dfw_pkg::MAX_EDGES))
    else $error("stack pointer past stack depth");

  a_fin_held: assert property (@(posedge clk) disable iff (rst)
    (state == dfw_pkg::ST_FIN) |-> held_valid)
    else $error("walk finished with no held result");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == dfw_pkg::ST_IDLE) |-> !held_valid)
    else $error("held result left behind in idle");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (result_stb && status != dfw_pkg::STATUS_OK) |-> (last && visited_node == '0))
    else $error("error beat without last flag");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_stb && last) |-> (state == dfw_pkg::ST_IDLE))
    else $error("last beat while walk still running");

endmodule

### design/graph_depth_first_walk.sv
// channel  | direction | handshake             | fields
// ---------+-----------+-----------------------+------------------------------------
// command  | in        | start && !busy        | func, vertex, row_end
// result   | out       | result_stb (1 cycle)  | visited_node, last, status
// config   | in        | cfg_wr_en             | cfg_wr_data -> node_count
//
// Append and clear beats leave busy low, so they can come back to back. A walk
// holds busy high while it pops the stack (read, then check), reads the row of
// each newly visited node and pushes its neighbors; the stack, row and edge
// memories each have a registered read. It closes out in ST_FIN, or in ST_ERR,
// which first flushes a held visit. A visit is held until its last flag is known;
// the receiver cannot stall results.
// Reset (rst, synchronous) clears the graph, visited map and node_count to 64;
// no memory clearing pass is needed.
module graph_depth_first_walk (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 func,
  input  logic [dfw_pkg::NODE_W-1:0] vertex,
  input  logic                       row_end,
  input  logic                       cfg_wr_en,
  input  logic [dfw_pkg::NODE_W-1:0] cfg_wr_data,
  output logic                       result_stb,
  output logic [dfw_pkg::NODE_W-1:0] visited_node,
  output logic                       last,
  output logic [1:0]                 status
);

  logic [dfw_pkg::NODE_W-1:0] node_count;
  logic [dfw_pkg::NODE_W-1:0] nn;
  logic                       take;
  logic                       walk_go;
  dfw_pkg::load_cmd_t         cmd;

  logic [dfw_pkg::ROW_AW-1:0]  row_addr;
  dfw_pkg::row_info_t          row_info;
  logic [dfw_pkg::EDGE_AW-1:0] edge_addr;
  logic [dfw_pkg::NODE_W-1:0]  edge_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dfw_pkg::NODE_W'(dfw_pkg::MAX_NODES);
    end else if (cfg_wr_en) begin
      node_count <= cfg_wr_data;
    end
  end

  assign nn = (node_count > dfw_pkg::NODE_W'(dfw_pkg::MAX_NODES)) ?
              dfw_pkg::NODE_W'(dfw_pkg::MAX_NODES) : node_count;

  assign take = start && !busy;
  assign walk_go = take && (func == dfw_pkg::FUNC_WALK);
  assign cmd.append = take && (func == dfw_pkg::FUNC_APPEND);
  assign cmd.clear = take && (func == dfw_pkg::FUNC_CLEAR);
  assign cmd.vertex = vertex;
  assign cmd.row_end = row_end;

  dfw_graph u_graph (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .row_addr  (row_addr),
    .row_info  (row_info),
    .edge_addr (edge_addr),
    .edge_data (edge_data)
  );

  dfw_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .walk_go      (walk_go),
    .start_vertex (vertex),
    .nn           (nn),
    .busy         (busy),
    .row_addr     (row_addr),
    .row_info     (row_info),
    .edge_addr    (edge_addr),
    .edge_data    (edge_data),
    .result_stb   (result_stb),
    .visited_node (visited_node),
    .last         (last),
    .status       (status)
  );

endmodule

### verif/graph_depth_first_walk_tb.sv
`timescale 1ns / 100ps

module graph_depth_first_walk_tb;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    BEAT_CMD,
    BEAT_PAUSE,
    BEAT_CFG
  } beat_kind_t;

  typedef struct packed {
    beat_kind_t                 kind;
    logic [1:0]                 func;
    logic [dfw_pkg::NODE_W-1:0] vertex;
    logic                       row_end;
    logic [dfw_pkg::NODE_W-1:0] cfg;
  } beat_t;

  typedef struct packed {
    logic [dfw_pkg::NODE_W-1:0] node;
    logic                       is_last;
    logic [1:0]                 code;
  } visit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func = dfw_pkg::FUNC_APPEND;
  logic [dfw_pkg::NODE_W-1:0] vertex = '0;
  logic row_end = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [dfw_pkg::NODE_W-1:0] cfg_wr_data = '0;
  logic result_stb;
  logic [dfw_pkg::NODE_W-1:0] visited_node;
  logic last;
  logic [1:0] status;

  graph_depth_first_walk u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .vertex       (vertex),
    .row_end      (row_end),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_stb   (result_stb),
    .visited_node (visited_node),
    .last         (last),
    .status       (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the graph, node count and walk stack
  logic [dfw_pkg::NODE_W-1:0] graph_edges [dfw_pkg::MAX_EDGES];
  logic [dfw_pkg::NODE_W-1:0] walk_stack [dfw_pkg::MAX_EDGES];
  int unsigned row_base [dfw_pkg::MAX_NODES];
  int unsigned row_len [dfw_pkg::MAX_NODES];
  bit visited [dfw_pkg::MAX_NODES];
  int unsigned fill_row;
  int unsigned edge_count;
  logic [dfw_pkg::NODE_W-1:0] node_limit;

  beat_t pending_beats[$];
  visit_t expected_visits[$];
  int fail_count = 0;
  int stim_count = 0;
  int quiet = 0;
  bit beat_taken = 1'b0;
  int gap_left = 0;
  int burst_left = 1;
  int cycle_count = 0;

  task automatic predict_walk(input logic [dfw_pkg::NODE_W-1:0] root);
    int unsigned nn, seen_cnt, sp, e, len, base, k;
    logic [1:0] err;
    visit_t v;
    visit_t found[$];
    nn = (node_limit > dfw_pkg::MAX_NODES) ? dfw_pkg::MAX_NODES : int'(node_limit);
    for (int i = 0; i < dfw_pkg::MAX_NODES; i++) visited[i] = 1'b0;
    seen_cnt = 0;
    err = dfw_pkg::STATUS_OK;
    if (root == 0 || root > nn) begin
      expected_visits.insert(expected_visits.size(),
                             '{node: '0, is_last: 1'b1, code: dfw_pkg::STATUS_RANGE});
      return;
    end
    walk_stack[0] = root;
    sp = 1;
    while (sp > 0 && seen_cnt < nn) begin
      sp--;
      e = 32'(walk_stack[sp]);
      if (e == 0 || e > nn) begin
        err = dfw_pkg::STATUS_RANGE;
        break;
      end
      if (visited[e-1]) continue;
      visited[e-1] = 1'b1;
      found.insert(found.size(),
                   '{node: dfw_pkg::NODE_W'(e), is_last: 1'b0, code: dfw_pkg::STATUS_OK});
      seen_cnt++;
      if (seen_cnt >= nn) break;
      len = row_len[e-1];
      base = row_base[e-1];
      // cannot trigger with MAX_EDGES total pushes, kept for completeness
      if (sp + len > dfw_pkg::MAX_EDGES) begin
        err = dfw_pkg::STATUS_OVERFLOW;
        break;
      end
      for (k = len; k > 0; k--) begin
        walk_stack[sp] = graph_edges[base + k - 1];
        sp++;
      end
    end
    if (err != dfw_pkg::STATUS_OK) begin
      found.insert(found.size(), '{node: '0, is_last: 1'b1, code: err});
    end else begin
      v = found[found.size()-1];
      v.is_last = 1'b1;
      found[found.size()-1] = v;
    end
    foreach (found[i]) expected_visits.insert(expected_visits.size(), found[i]);
  endtask

  task automatic apply_command(input logic [1:0] f, input logic [dfw_pkg::NODE_W-1:0] v,
                               input logic re);
    case (f)
      dfw_pkg::FUNC_APPEND: begin
        if (fill_row < dfw_pkg::MAX_NODES && edge_count < dfw_pkg::MAX_EDGES) begin
          if (row_len[fill_row] == 0) row_base[fill_row] = edge_count;
          graph_edges[edge_count] = v;
          edge_count++;
          row_len[fill_row]++;
        end
        if (re && fill_row < dfw_pkg::MAX_NODES) fill_row++;
      end
      dfw_pkg::FUNC_WALK: predict_walk(v);
      dfw_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < dfw_pkg::MAX_NODES; i++) row_len[i] = 0;
        fill_row = 0;
        edge_count = 0;
      end
      default: ;
    endcase
  endtask

  // sender: bursts of beats with random gaps; pause and config beats wait for idle
  always @(negedge clk) begin : drive_beats
    beat_t head;
    logic nxt_start;
    logic nxt_wr;
    nxt_start = start && !beat_taken;
    nxt_wr = 1'b0;
    if (!rst && !nxt_start && pending_beats.size() > 0) begin
      head = pending_beats[0];
      if (head.kind == BEAT_CMD) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          pending_beats.delete(0);
          nxt_start = 1'b1;
          func <= head.func;
          vertex <= head.vertex;
          row_end <= head.row_end;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end else if (quiet >= SETTLE_CYCLES) begin
        pending_beats.delete(0);
        if (head.kind == BEAT_CFG) begin
          nxt_wr = 1'b1;
          cfg_wr_data <= head.cfg;
        end
      end
    end
    start <= nxt_start;
    cfg_wr_en <= nxt_wr;
  end

  always @(posedge clk) begin : watch_results
    visit_t got;
    visit_t want;
    if (rst) begin
      node_limit = dfw_pkg::NODE_W'(dfw_pkg::MAX_NODES);
      for (int i = 0; i < dfw_pkg::MAX_NODES; i++) row_len[i] = 0;
      fill_row = 0;
      edge_count = 0;
      beat_taken = 1'b0;
      quiet = 0;
    end else begin
      if (result_stb) begin
        got = '{node: visited_node, is_last: last, code: status};
        if (expected_visits.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result node=%0d last=%0b status=%0d",
                   $time, got.node, got.is_last, got.code);
        end else begin
          want = expected_visits.pop_front();
          if (got != want) begin
            fail_count++;
            $display("%0t: expected node %0d last %0b status %0d, got %0d %0b %0d",
                     $time, want.node, want.is_last, want.code,
                     got.node, got.is_last, got.code);
          end
        end
      end
      if (cfg_wr_en) node_limit = cfg_wr_data;
      beat_taken = start && !busy;
      if (beat_taken) apply_command(func, vertex, row_end);
      if (expected_visits.size() == 0 && !busy && !start && !result_stb) quiet++;
      else quiet = 0;
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic add_cmd(input logic [1:0] f, input logic [dfw_pkg::NODE_W-1:0] v,
                         input logic re);
    pending_beats.insert(pending_beats.size(),
                         '{kind: BEAT_CMD, func: f, vertex: v, row_end: re, cfg: '0});
    stim_count++;
  endtask

  task automatic add_pause();
    pending_beats.insert(pending_beats.size(),
                         '{kind: BEAT_PAUSE, func: dfw_pkg::FUNC_APPEND, vertex: '0,
                           row_end: 1'b0, cfg: '0});
  endtask

  task automatic add_cfg(input logic [dfw_pkg::NODE_W-1:0] n);
    pending_beats.insert(pending_beats.size(),
                         '{kind: BEAT_CFG, func: dfw_pkg::FUNC_APPEND, vertex: '0,
                           row_end: 1'b0, cfg: n});
  endtask

  task automatic load_rows(input int rows, input int lim, input int deg_max);
    int deg;
    logic [dfw_pkg::NODE_W-1:0] nb;
    for (int r = 0; r < rows; r++) begin
      deg = $urandom_range(1, deg_max);
      for (int j = 0; j < deg; j++) begin
        nb = ($urandom_range(0, 19) == 0) ? dfw_pkg::NODE_W'($urandom_range(0, 127))
                                          : dfw_pkg::NODE_W'($urandom_range(1, lim));
        add_cmd(dfw_pkg::FUNC_APPEND, nb, j == deg - 1);
      end
    end
  endtask

  initial begin
    int phase;
    int count_cfg;
    int lim;
    int walks;

    // directed: empty graph, bad start ids, ignored func
    add_cmd(dfw_pkg::FUNC_WALK, 7'd1, 1'b0);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd0, 1'b1);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd65, 1'b0);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd127, 1'b0);
    add_cmd(FUNC_NOP, 7'd127, 1'b1);
    // 1:{2,3} 2:{4} 3:{1} 4:{127} -> walk runs into an out of range neighbor
    add_cmd(dfw_pkg::FUNC_APPEND, 7'd2, 1'b0);
    add_cmd(dfw_pkg::FUNC_APPEND, 7'd3, 1'b1);
    add_cmd(dfw_pkg::FUNC_APPEND, 7'd4, 1'b1);
    add_cmd(dfw_pkg::FUNC_APPEND, 7'd1, 1'b1);
    add_cmd(dfw_pkg::FUNC_APPEND, 7'd127, 1'b1);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd1, 1'b0);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd3, 1'b1);
    add_cmd(dfw_pkg::FUNC_CLEAR, 7'd127, 1'b1);
    add_cmd(dfw_pkg::FUNC_APPEND, 7'd2, 1'b1);
    add_cmd(dfw_pkg::FUNC_APPEND, 7'd1, 1'b1);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd64, 1'b0);
    // all nodes seen ends the walk, also before the start row is pushed
    add_cfg(7'd2);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd1, 1'b0);
    add_cfg(7'd1);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd1, 1'b0);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd2, 1'b0);
    add_cfg(7'd0);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd1, 1'b0);
    add_cfg(7'd127);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd64, 1'b0);
    add_cmd(dfw_pkg::FUNC_WALK, 7'd2, 1'b0);
    add_pause();

    phase = 0;
    while (stim_count < 100) begin
      phase++;
      if (phase == 2) begin
        // every row used while the edge store still has room; row pointer saturates
        add_cfg(7'd64);
        add_cmd(dfw_pkg::FUNC_CLEAR, 7'd0, 1'b1);
        for (int i = 0; i < 66; i++)
          add_cmd(dfw_pkg::FUNC_APPEND, dfw_pkg::NODE_W'($urandom_range(1, 64)), 1'b1);
        add_cmd(dfw_pkg::FUNC_WALK, dfw_pkg::NODE_W'($urandom_range(1, 64)), 1'b0);
        add_cmd(dfw_pkg::FUNC_WALK, dfw_pkg::NODE_W'($urandom_range(1, 64)), 1'b0);
      end else begin
        case ($urandom_range(0, 9))
          0: count_cfg = 0;
          1: count_cfg = 1;
          2: count_cfg = 64;
          3: count_cfg = 127;
          default: count_cfg = $urandom_range(2, 12);
        endcase
        lim = (count_cfg == 0) ? 4 : (count_cfg > 64) ? 64 : count_cfg;
        add_cfg(dfw_pkg::NODE_W'(count_cfg));
        add_cmd(dfw_pkg::FUNC_CLEAR, dfw_pkg::NODE_W'($urandom_range(0, 127)),
                1'($urandom_range(0, 1)));
        load_rows((lim > 12) ? $urandom_range(4, 12) : $urandom_range(1, lim), lim, 4);
        if ($urandom_range(0, 3) == 0)
          add_cmd(FUNC_NOP, dfw_pkg::NODE_W'($urandom_range(0, 127)),
                  1'($urandom_range(0, 1)));
        walks = $urandom_range(2, 4);
        for (int w = 0; w < walks; w++)
          add_cmd(dfw_pkg::FUNC_WALK,
                  ($urandom_range(0, 7) == 0) ? dfw_pkg::NODE_W'($urandom_range(0, 127))
                                              : dfw_pkg::NODE_W'($urandom_range(1, lim)),
                  1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) == 0) add_pause();
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_beats.size() > 0 || start || quiet < SETTLE_CYCLES) @(negedge clk);
    repeat (40) @(negedge clk);
    if (expected_visits.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_visits.size());
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### graph_depth_first_walk.f
design/dfw_pkg.sv
design/dfw_graph.sv
design/dfw_walker.sv
design/graph_depth_first_walk.sv
verif/graph_depth_first_walk_tb.sv
